>>> rtl/core/dpli_pkg.sv
`default_nettype none

package dpli_pkg;

	localparam int unsigned MagW   = 15;
	localparam int unsigned LenW   = 8;
	localparam int unsigned HoldW  = 16;
	localparam int unsigned PotW   = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned SumW   = PotW + 2;

	localparam logic [MagW-1:0]  MagReset  = MagW'(18000);
	localparam logic [LenW-1:0]  LenReset  = LenW'(25);
	localparam logic [HoldW-1:0] HoldReset = HoldW'(100);

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CFG_MAGNITUDE = 2'd0,
		CFG_PULSE_LEN = 2'd1,
		CFG_PING_HOLD = 2'd2
	} cfg_idx_t;

	// Per-tick control handed from the input stage to the pulse integrator.
	typedef struct packed {
		logic advance;
		logic excite;
		logic inhibit;
		logic decay;
	} pulse_ctl_t;

	function automatic logic signed [PotW-1:0] sat16(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] hi;
		logic signed [SumW-1:0] lo;
		hi = SumW'(32767);
		lo = -SumW'(32768);
		if (v > hi) begin
			sat16 = 16'sh7fff;
		end else if (v < lo) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = v[PotW-1:0];
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/dendrite_pulse_leaky_integrator_top.sv
// Dendrite pulse leaky integrator, one result per millisecond tick.
// Each input transfer carries one tick: two ping flags, excitatory and
// inhibitory pulse flags, and a decay flag. Each tick yields exactly one
// output transfer with the potential, two release flags and the dendrite
// activity flag. Both channels use valid/ready handshakes.
// A tick is captured in an input register, evaluated by a single pass of
// short logic against the integrator state, and written to the result
// register once that register is free or being emptied, so out_valid is
// registered behind the input and result registers. Throughput is one
// tick per cycle while the receiver keeps up; the state update of one
// tick is complete before the next tick leaves the input register.
// When the receiver stalls, the result register holds its transfer, the
// input register fills, and then in_ready drops until the result is taken.
// Reset clears the integrator and ping timer state and the pipeline valid
// flags, and loads the default configuration (magnitude 18000, pulse
// length 25, ping hold 100). Configuration writes take effect at once
// and are intended only while the block is idle.
`default_nettype none

module dendrite_pulse_leaky_integrator_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          ping_a,
	input  wire logic                          ping_b,
	input  wire logic                          pulse_excite,
	input  wire logic                          pulse_inhibit,
	input  wire logic                          decay_tick,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [dpli_pkg::PotW-1:0]   potential,
	output logic                               release_port_zero,
	output logic                               release_port_one,
	output logic                               dendrite_active,
	input  wire logic                          cfg_we,
	input  wire logic [dpli_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [dpli_pkg::CfgDataW-1:0] cfg_data
);
	import dpli_pkg::*;

	// Configuration registers.
	logic [MagW-1:0]  magnitude_q;
	logic [LenW-1:0]  on_ticks_q;
	logic [HoldW-1:0] ping_hold_q;

	// Input stage.
	logic valid_s1;
	logic ping_a_s1;
	logic ping_b_s1;
	logic excite_s1;
	logic inhibit_s1;
	logic decay_s1;

	// Result register.
	logic                   valid_q;
	logic signed [PotW-1:0] potential_q;
	logic                   rel_zero_q;
	logic                   rel_one_q;
	logic                   active_q;

	logic                   advance;
	pulse_ctl_t             ctl;
	logic                   rel_line0;
	logic                   rel_line1;
	logic signed [PotW-1:0] pot_next;
	logic                   active_next;

	// The input stage moves on whenever the result register is free or
	// is being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnitude_q <= MagReset;
			on_ticks_q  <= LenReset;
			ping_hold_q <= HoldReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAGNITUDE: magnitude_q <= cfg_data[MagW-1:0];
				CFG_PULSE_LEN: on_ticks_q  <= cfg_data[LenW-1:0];
				CFG_PING_HOLD: ping_hold_q <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ping_a_s1  <= ping_a;
			ping_b_s1  <= ping_b;
			excite_s1  <= pulse_excite;
			inhibit_s1 <= pulse_inhibit;
			decay_s1   <= decay_tick;
		end
	end

	assign ctl = '{advance: advance, excite: excite_s1, inhibit: inhibit_s1,
		decay: decay_s1};

	// Line 0 is pinged by ping_a and reports on release_port_one; line 1
	// is pinged by ping_b and reports on release_port_zero.
	dpli_ping u_ping_line0 (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.ping         (ping_a_s1),
		.hold         (ping_hold_q),
		.release_flag (rel_line0)
	);

	dpli_ping u_ping_line1 (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.ping         (ping_b_s1),
		.hold         (ping_hold_q),
		.release_flag (rel_line1)
	);

	dpli_pulse u_pulse (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.magnitude    (magnitude_q),
		.on_ticks     (on_ticks_q),
		.potential    (pot_next),
		.active       (active_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			potential_q <= pot_next;
			rel_zero_q  <= rel_line1;
			rel_one_q   <= rel_line0;
			active_q    <= active_next;
		end
	end

	assign out_valid         = valid_q;
	assign potential         = potential_q;
	assign release_port_zero = rel_zero_q;
	assign release_port_one  = rel_one_q;
	assign dendrite_active   = active_q;

endmodule

`default_nettype wire

>>> rtl/core/dpli_ping.sv
`default_nettype none

module dpli_ping (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic                       ping,
	input  wire logic [dpli_pkg::HoldW-1:0] hold,
	output logic                            release_flag
);
	import dpli_pkg::*;

	logic [HoldW-1:0] count_q;
	logic [HoldW-1:0] loaded;
	logic [HoldW-1:0] count_next;

	// A ping reloads the countdown, which still ticks down in the same tick.
	always_comb begin
		release_flag = !ping && (count_q == HoldW'(1));
		loaded       = ping ? hold : count_q;
		count_next   = (loaded != '0) ? loaded - HoldW'(1) : loaded;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/dpli_pulse.sv
`default_nettype none

module dpli_pulse (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire dpli_pkg::pulse_ctl_t             ctl,
	input  wire logic [dpli_pkg::MagW-1:0]        magnitude,
	input  wire logic [dpli_pkg::LenW-1:0]        on_ticks,
	output logic signed [dpli_pkg::PotW-1:0]      potential,
	output logic                                  active
);
	import dpli_pkg::*;

	logic                   on_q;
	logic                   inhib_q;
	logic [LenW-1:0]        age_q;
	logic signed [PotW-1:0] residual_q;

	logic                   on_a;
	logic                   inhib_a;
	logic [LenW-1:0]        age_a;
	logic [LenW-1:0]        age_inc;
	logic                   switch_off;
	logic [LenW-1:0]        age_next;
	logic signed [SumW-1:0] mag_s;
	logic signed [SumW-1:0] dep_sum;
	logic signed [PotW-1:0] residual_dep;
	logic signed [PotW+5:0] ext;
	logic signed [PotW+5:0] prod;
	logic signed [PotW+5:0] biased;
	logic signed [PotW+5:0] scaled;
	logic signed [PotW-1:0] residual_next;
	logic signed [SumW-1:0] pot_sum;

	always_comb begin
		// Inhibitory pulse is handled after excitatory, so it wins a tie.
		on_a    = on_q | ctl.excite | ctl.inhibit;
		inhib_a = ctl.inhibit ? 1'b1 : (ctl.excite ? 1'b0 : inhib_q);
		age_a   = (ctl.excite | ctl.inhibit) ? '0 : age_q;
		age_inc = age_a + LenW'(1);

		switch_off = on_a && (age_inc >= on_ticks);
		active     = on_a && !switch_off;
		age_next   = (on_a && !switch_off) ? age_inc : (on_a ? '0 : age_a);

		mag_s   = $signed({{(SumW-MagW){1'b0}}, magnitude});
		dep_sum = inhib_a ? SumW'(residual_q) - mag_s : SumW'(residual_q) + mag_s;
		residual_dep = switch_off ? sat16(dep_sum) : residual_q;

		// Multiply by 63 as x*64 - x, then divide by 64 rounding toward zero.
		ext    = (PotW+6)'(residual_dep);
		prod   = (ext <<< 6) - ext;
		biased = prod + (prod[PotW+5] ? (PotW+6)'(63) : (PotW+6)'(0));
		scaled = biased >>> 6;
		residual_next = ctl.decay ? scaled[PotW-1:0] : residual_dep;

		pot_sum = SumW'(residual_next);
		if (active) begin
			pot_sum = inhib_a ? pot_sum - mag_s : pot_sum + mag_s;
		end
		potential = sat16(pot_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q       <= 1'b0;
			inhib_q    <= 1'b0;
			age_q      <= '0;
			residual_q <= '0;
		end else if (ctl.advance) begin
			on_q       <= active;
			inhib_q    <= inhib_a;
			age_q      <= age_next;
			residual_q <= residual_next;
		end
	end

endmodule

`default_nettype wire

>>> verif/tb_dendrite_pulse_leaky_integrator_top.sv
`timescale 1ns / 1ps

module tb_dendrite_pulse_leaky_integrator_top;

	import dpli_pkg::*;

	// Register index with no register behind it; writes to it must be ignored.
	localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

	// Long receiver hold-off, long enough to fill the block and stall its input.
	localparam int HoldOffCycles = 400;

	// One millisecond tick as it crosses the input channel.
	typedef struct packed {
		logic ping_a;
		logic ping_b;
		logic excite;
		logic inhibit;
		logic decay;
	} tick_t;

	// A tick waiting to be offered, with the idle cycles the sender adds after it.
	typedef struct {
		tick_t t;
		int    gap;
	} queued_tick_t;

	// What the block reports for one tick.
	typedef struct packed {
		logic signed [PotW-1:0] potential;
		logic                   rel_zero;
		logic                   rel_one;
		logic                   active;
	} tick_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   ping_a = 1'b0;
	logic                   ping_b = 1'b0;
	logic                   pulse_excite = 1'b0;
	logic                   pulse_inhibit = 1'b0;
	logic                   decay_tick = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic signed [PotW-1:0] potential;
	logic                   release_port_zero;
	logic                   release_port_one;
	logic                   dendrite_active;
	logic                   cfg_we = 1'b0;
	logic [CfgIdxW-1:0]     cfg_index = '0;
	logic [CfgDataW-1:0]    cfg_data = '0;

	dendrite_pulse_leaky_integrator_top DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.ping_a            (ping_a),
		.ping_b            (ping_b),
		.pulse_excite      (pulse_excite),
		.pulse_inhibit     (pulse_inhibit),
		.decay_tick        (decay_tick),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.potential         (potential),
		.release_port_zero (release_port_zero),
		.release_port_one  (release_port_one),
		.dendrite_active   (dendrite_active),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// The testbench's own copy of the configuration and of the integrator state.
	logic [MagW-1:0]        mag_m;
	logic [LenW-1:0]        len_m;
	logic [HoldW-1:0]       hold_m;
	logic                   on_m;
	logic                   inh_m;
	logic [LenW-1:0]        age_m;
	logic signed [PotW-1:0] resid_m;
	logic [HoldW-1:0]       countdown_m [2];

	queued_tick_t pending_ticks[$];
	tick_result_t predicted_results[$];

	// Bookkeeping shared between the stimulus, the driver and the monitor.
	int ticks_sent = 0;
	int results_seen = 0;
	int releases_seen = 0;
	int settings_used = 0;
	int mismatches = 0;
	bit rx_quiet = 1'b1;
	int hold_requests = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Saturate a sum to the signed 16-bit range.
	function automatic logic signed [PotW-1:0] clamp16(input int v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

	// One line's ping hold timer. A ping reloads the countdown and the same tick
	// already counts it down, so release fires on a later unpinged tick that
	// finds the count at one; a hold of zero or one therefore never releases.
	function automatic logic advance_hold_timer(input int line, input logic ping);
		logic fired;
		fired = 1'b0;
		if (ping) begin
			countdown_m[line] = hold_m;
		end else if (countdown_m[line] == 16'd1) begin
			fired = 1'b1;
		end
		if (countdown_m[line] != 16'd0) begin
			countdown_m[line] = countdown_m[line] - 16'd1;
		end
		return fired;
	endfunction

	// Advance the predicted state by one tick and return what the block must report.
	function automatic tick_result_t integrate_tick(input tick_t t);
		tick_result_t r;
		int           sum;
		r.rel_one = advance_hold_timer(0, t.ping_a);
		if (t.excite) begin
			inh_m = 1'b0;
			on_m  = 1'b1;
			age_m = '0;
		end
		r.rel_zero = advance_hold_timer(1, t.ping_b);
		// The inhibitory pulse is handled last, so it wins when both arrive together.
		if (t.inhibit) begin
			inh_m = 1'b1;
			on_m  = 1'b1;
			age_m = '0;
		end
		// A pulse length of zero behaves like one: the pulse ends in its own tick.
		if (on_m) begin
			age_m = age_m + 8'd1;
			if (age_m >= len_m) begin
				on_m  = 1'b0;
				age_m = '0;
				if (inh_m) begin
					resid_m = clamp16(int'(resid_m) - int'(mag_m));
				end else begin
					resid_m = clamp16(int'(resid_m) + int'(mag_m));
				end
			end
		end
		// Signed division truncates toward zero, so small negative residuals reach zero.
		if (t.decay) begin
			sum = int'(resid_m) * 63;
			resid_m = 16'(sum / 64);
		end
		sum = int'(resid_m);
		if (on_m) begin
			sum = inh_m ? sum - int'(mag_m) : sum + int'(mag_m);
		end
		r.potential = clamp16(sum);
		r.active    = on_m;
		return r;
	endfunction

	function automatic tick_t mk_tick(input logic pa, input logic pb, input logic ex,
		input logic ih, input logic dc);
		tick_t t;
		t.ping_a  = pa;
		t.ping_b  = pb;
		t.excite  = ex;
		t.inhibit = ih;
		t.decay   = dc;
		return t;
	endfunction

	// Each event flag is set with odds of one in density+1; decay is set one tick in four.
	function automatic tick_t rand_tick(input int density);
		return mk_tick($urandom_range(0, density) == 0, $urandom_range(0, density) == 0,
			$urandom_range(0, density) == 0, $urandom_range(0, density) == 0,
			$urandom_range(0, 3) == 0);
	endfunction

	function automatic void push_tick(input tick_t t, input int gap);
		queued_tick_t q;
		q.t   = t;
		q.gap = gap;
		pending_ticks.push_back(q);
	endfunction

	// Driver: offers queued ticks, holds each one until its transfer, and predicts
	// the result at the edge that completes the transfer. After each transfer it
	// idles for the gap that came with the tick.
	queued_tick_t cur_tick;
	int           gap_left;
	logic         offer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			ping_a        <= 1'b0;
			ping_b        <= 1'b0;
			pulse_excite  <= 1'b0;
			pulse_inhibit <= 1'b0;
			decay_tick    <= 1'b0;
			gap_left = 0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				predicted_results.push_back(integrate_tick(cur_tick.t));
				ticks_sent++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ticks.size() > 0) begin
					cur_tick = pending_ticks.pop_front();
					gap_left = cur_tick.gap;
					offer = 1'b1;
					ping_a        <= cur_tick.t.ping_a;
					ping_b        <= cur_tick.t.ping_b;
					pulse_excite  <= cur_tick.t.excite;
					pulse_inhibit <= cur_tick.t.inhibit;
					decay_tick    <= cur_tick.t.decay;
				end
			end
			in_valid <= offer;
		end
	end

	// Monitor: checks every result transfer against the oldest prediction, then
	// stalls for a random count of cycles unless the receiver is in a quiet phase.
	// A hold-off request from the stimulus blocks the receiver for a long stretch.
	tick_result_t want;
	int           stall_left;
	int           hold_left;
	int           holds_served;
	logic         take;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			holds_served = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (release_port_zero || release_port_one) begin
					releases_seen++;
				end
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Result transfer with nothing predicted: potential %0d rel0 %0b rel1 %0b active %0b",
							potential, release_port_zero, release_port_one, dendrite_active);
					end
				end else begin
					want = predicted_results.pop_front();
					if (potential !== want.potential || release_port_zero !== want.rel_zero ||
						release_port_one !== want.rel_one || dendrite_active !== want.active) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch on result %0d: expected potential %0d rel0 %0b rel1 %0b active %0b, got potential %0d rel0 %0b rel1 %0b active %0b",
								results_seen, want.potential, want.rel_zero, want.rel_one, want.active,
								potential, release_port_zero, release_port_one, dendrite_active);
						end
					end
				end
				stall_left = rx_quiet ? 0 : $urandom_range(0, 17);
			end
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = HoldOffCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
			out_ready <= take;
		end
	end

	// Writes one register and mirrors it into the predicted configuration. The
	// write enable is left high so back-to-back writes never lower and raise it
	// in one step; the caller lowers it after the last write.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_MAGNITUDE: mag_m  = val[MagW-1:0];
			CFG_PULSE_LEN: len_m  = val[LenW-1:0];
			CFG_PING_HOLD: hold_m = val[HoldW-1:0];
			default: ;
		endcase
	endtask

	// Loads all three registers, plus a stray write to the unused index.
	task automatic configure(input logic [CfgDataW-1:0] mag, input logic [CfgDataW-1:0] len,
		input logic [CfgDataW-1:0] hold);
		write_reg(CFG_MAGNITUDE, mag);
		write_reg(CFG_PULSE_LEN, len);
		write_reg(CFG_PING_HOLD, hold);
		write_reg(CfgSpare, 16'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Waits until every queued tick has made its transfer and every predicted
	// result has arrived, then lets the pipeline registers settle with margin.
	task automatic drain();
		@(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || predicted_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int phase;
		int k;
		int density;
		bit quiet;

		// Predicted state after reset, matching the block's defaults.
		mag_m   = MagReset;
		len_m   = LenReset;
		hold_m  = HoldReset;
		on_m    = 1'b0;
		inh_m   = 1'b0;
		age_m   = '0;
		resid_m = '0;
		countdown_m[0] = '0;
		countdown_m[1] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed ticks at the reset configuration: each pulse alone, both pulses
		// at once (inhibitory wins), every flag set, and an empty tick.
		@(negedge clk);
		push_tick(mk_tick(0, 0, 1, 0, 0), 0);
		push_tick(mk_tick(0, 0, 0, 1, 0), 0);
		push_tick(mk_tick(0, 0, 1, 1, 0), 0);
		push_tick(mk_tick(1, 1, 1, 1, 1), 0);
		push_tick(mk_tick(0, 0, 0, 0, 0), 0);
		drain();

		// Unit magnitude with single-tick pulses: a negative residual of one decays
		// to zero, and a hold of two releases each line on the tick after its ping.
		configure(16'd1, 16'd1, 16'd2);
		@(negedge clk);
		push_tick(mk_tick(0, 0, 0, 1, 0), 0);
		push_tick(mk_tick(0, 0, 0, 0, 1), 0);
		push_tick(mk_tick(1, 0, 0, 0, 0), 0);
		push_tick(mk_tick(0, 0, 0, 0, 0), 0);
		push_tick(mk_tick(0, 1, 0, 0, 0), 0);
		push_tick(mk_tick(0, 0, 0, 0, 0), 0);
		push_tick(mk_tick(1, 1, 0, 0, 0), 0);
		push_tick(mk_tick(0, 0, 0, 0, 0), 0);
		drain();

		// Full magnitude, zero pulse length and a hold of one: the residual
		// saturates both ways and the pinged line never releases.
		configure(16'd32767, 16'd0, 16'd1);
		@(negedge clk);
		push_tick(mk_tick(1, 0, 1, 0, 0), 0);
		push_tick(mk_tick(0, 0, 1, 0, 0), 0);
		push_tick(mk_tick(0, 0, 0, 0, 0), 0);
		push_tick(mk_tick(0, 0, 0, 1, 0), 0);
		push_tick(mk_tick(0, 0, 0, 1, 0), 0);
		push_tick(mk_tick(0, 0, 0, 1, 0), 0);
		push_tick(mk_tick(0, 0, 0, 0, 1), 0);
		drain();

		// Random phases, each under its own setting. Every phase starts from an
		// idle block and the sender pauses at its end until all results are in.
		for (phase = 0; phase < 8; phase++) begin
			density = $urandom_range(2, 8);
			case (phase)
				0: begin
					// Saturating sums while a two-tick pulse is held on.
					configure(16'd32767, 16'd2, 16'd1);
					density = 1;
				end
				1: configure(16'($urandom_range(0, 32767)), 16'($urandom_range(2, 20)),
					16'($urandom_range(2, 30)));
				2: configure(16'd0, 16'd0, 16'd0);
				3: configure(16'($urandom_range(0, 32767)), 16'd255, 16'd65535);
				4: configure(16'd18000, 16'($urandom_range(1, 8)), 16'($urandom_range(2, 8)));
				5: configure(16'($urandom), 16'($urandom), 16'($urandom));
				default: configure(16'($urandom_range(0, 32767)), 16'($urandom_range(1, 12)),
					16'($urandom_range(1, 40)));
			endcase
			quiet = (phase % 3 == 1);
			@(negedge clk);
			rx_quiet = quiet;
			// In one phase the receiver holds off while the sender streams ticks
			// back to back, so the block fills and drops its input ready.
			if (phase == 3) begin
				hold_requests++;
			end
			for (k = 0; k < 75; k++) begin
				push_tick(rand_tick(density), (quiet || phase == 3) ? 0 : $urandom_range(0, 17));
			end
			drain();
		end

		$display("Sent %0d ticks under %0d register settings, checked %0d results, %0d with a release.",
			ticks_sent, settings_used, results_seen, releases_seen);
		$display("Covered saturation, pulse polarity priority, decay truncation and ping hold expiry.");
		if (mismatches == 0) begin
			$display("tb_dendrite_pulse_leaky_integrator_top passed");
		end else begin
			$display("%0d mismatching result transfers.", mismatches);
			$display("tb_dendrite_pulse_leaky_integrator_top failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Timeout with %0d ticks queued and %0d results outstanding.",
			pending_ticks.size(), predicted_results.size());
		$display("tb_dendrite_pulse_leaky_integrator_top failed");
		$finish;
	end

endmodule
